// ----- src/sorted_free_list_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted free-list allocator
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SORTED_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SFLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SFLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Constants, payload types, command and status structs of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfla_pkg;

    localparam int POOL_BYTES = 4096;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = 8 * WORD_BYTES;
    localparam int POOL_ROWS  = POOL_BYTES / WORD_BYTES;
    localparam int ROW_W      = $clog2(POOL_ROWS);
    localparam int LANE_W     = $clog2(WORD_BYTES);
    localparam int OFF_W      = 12;
    localparam int ADDR_W     = $clog2(POOL_BYTES) + 1;
    localparam int HDR_OCC    = WORD_BYTES;
    localparam int HDR_FREE   = 2 * WORD_BYTES;
    localparam int MAX_WALK   = POOL_BYTES / (2 * WORD_BYTES) + 2;
    localparam int STEP_W     = $clog2(MAX_WALK + 1);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FIT_W      = 2;
    localparam int POOL_RESET = (4096 < POOL_BYTES) ? 4096 : POOL_BYTES;

    // register indexes
    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_POOL_BYTES = 1'b1;

    // fit modes
    localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

    // request types
    localparam logic REQ_ALLOC = 1'b0;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_NOMEM = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [OFF_W-1:0] request_bytes;
        logic [OFF_W-1:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] block_offset;
        logic [OFF_W-1:0] granted_bytes;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_A_CHECK,
        ST_A_SZ,
        ST_A_NX,
        ST_A_DONE,
        ST_A_W1,
        ST_A_W2,
        ST_A_W3,
        ST_A_W4,
        ST_F_RANGE,
        ST_F_SIZE,
        ST_F_CHECK,
        ST_F_SZ,
        ST_F_NX,
        ST_F_JUDGE,
        ST_F_MSZ,
        ST_F_MLK,
        ST_F_W1,
        ST_F_W2,
        ST_F_W3
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CUR,
        RD_CUR_LINK,
        RD_HDR,
        RD_NXT,
        RD_NXT_LINK
    } rd_sel_t;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_SPLIT_SIZE,
        WR_SPLIT_LINK,
        WR_PT_LINK,
        WR_T_SIZE,
        WR_PREV_SIZE,
        WR_PREV_LINK,
        WR_HDR_SIZE,
        WR_HDR_LINK,
        WR_PREV_TO_HDR
    } wr_sel_t;

    typedef struct packed {
        logic       load;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        logic       step;
        logic       cap_sz;
        logic       a_eval;
        logic       head_alloc;
        logic       cap_s;
        logic       f_prev;
        logic       f_adv;
        logic       f_nxt;
        logic       link_init;
        logic       merge_sz;
        logic       merge_lk;
        logic       head_free;
        logic       clear_start;
        logic       clear_en;
        logic       result;
        logic [1:0] res_status;
        logic       res_grant;
    } cmd_t;

    typedef struct packed {
        logic walk_ok;
        logic a_stop;
        logic have_t;
        logic split;
        logic have_pt;
        logic range_bad;
        logic size_bad;
        logic cur_ge_hdr;
        logic f_stop;
        logic overlap;
        logic merge_next;
        logic merge_prev;
        logic have_prev;
        logic clear_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- src/sorted_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// sorted_free_list_allocator
// Address-ordered free-list allocator with first, best and worst fit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  request   | start && !busy         | request (req_type, request_bytes,
//            |                        |          free_offset)
//  result    | done, one cycle        | result (status, block_offset,
//            |                        |         granted_bytes)
//  config    | psel&penable&pwrite    | paddr, pwdata, prdata, pready
//
// An allocate keeps busy high while it walks the free-list blocks and writes
// the headers; a free keeps it high while it walks the blocks below the freed one.
// The result strobe is registered and rises as busy falls.
// Each list step reads the size and link words through the single read port
// of the byte-banked pool memory, so latency grows with list length.
// After reset, and after every pool size write, a clearing pass over all 512
// pool rows runs with busy high. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_free_list_allocator
    import sfla_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_t                  request,
    output logic                       done,
    output res_t                       result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [FIT_W-1:0]  fit_mode;
    logic [ADDR_W-1:0] pool_bytes;
    logic              pool_wr;
    cmd_t              cmd;
    stat_t             stat;

    sfla_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fit_mode   (fit_mode),
        .pool_bytes (pool_bytes),
        .pool_wr    (pool_wr)
    );

    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .pool_wr  (pool_wr),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    sfla_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .fit_mode   (fit_mode),
        .pool_bytes (pool_bytes),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- src/sfla_ram.sv -----
// ----------------------------------------------------------------------------
// sfla_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- src/sfla_regs.sv -----
// ----------------------------------------------------------------------------
// sfla_regs
// APB-style configuration registers: fit mode and pool size.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_regs
    import sfla_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [FIT_W-1:0]      fit_mode,
    output logic      [ADDR_W-1:0]     pool_bytes,
    output logic                       pool_wr
);

    logic              wr_en;
    logic              reg_idx;
    logic [ADDR_W-1:0] pool_raw;
    logic [ADDR_W-1:0] pool_clamped;
    logic [FIT_W-1:0]  fit_mode_reg;
    logic [ADDR_W-1:0] pool_bytes_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // clamp pool size into the legal range
    assign pool_raw = pwdata[ADDR_W-1:0];
    always_comb
    begin
        pool_clamped = pool_raw;
        if (pool_raw < ADDR_W'(HDR_FREE))
        begin
            pool_clamped = ADDR_W'(HDR_FREE);
        end
        else if (pool_raw > ADDR_W'(POOL_BYTES))
        begin
            pool_clamped = ADDR_W'(POOL_BYTES);
        end
    end

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= '0;
            pool_bytes_reg <= ADDR_W'(POOL_RESET);
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_FIT_MODE)
            begin
                fit_mode_reg <= pwdata[FIT_W-1:0];
            end
            else
            begin
                pool_bytes_reg <= pool_clamped;
            end
        end
    end

    assign pool_wr    = wr_en && (reg_idx == REG_POOL_BYTES);
    assign fit_mode   = fit_mode_reg;
    assign pool_bytes = pool_bytes_reg;

    // read back
    always_comb
    begin
        if (reg_idx == REG_FIT_MODE)
        begin
            prdata = CFG_DATA_W'(fit_mode_reg);
        end
        else
        begin
            prdata = CFG_DATA_W'(pool_bytes_reg);
        end
    end

endmodule

`default_nettype wire

// ----- src/sfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfla_ctrl
// Controller state machine: sequences list walks, header writes and results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_free_list_allocator_assert.svh"

module sfla_ctrl
    import sfla_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  req_type,
    input  wire logic  pool_wr,
    input  wire stat_t stat,
    output logic       busy,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_ALLOC) ? ST_A_CHECK : ST_F_RANGE;
                end
            end
            ST_CLEAR:   state_next = stat.clear_last ? ST_IDLE : ST_CLEAR;
            ST_A_CHECK: state_next = stat.walk_ok ? ST_A_SZ : ST_A_DONE;
            ST_A_SZ:    state_next = ST_A_NX;
            ST_A_NX:    state_next = stat.a_stop ? ST_A_DONE : ST_A_CHECK;
            ST_A_DONE:
            begin
                if (!stat.have_t)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = stat.split ? ST_A_W1 : ST_A_W3;
                end
            end
            ST_A_W1:    state_next = ST_A_W2;
            ST_A_W2:    state_next = ST_A_W3;
            ST_A_W3:    state_next = ST_A_W4;
            ST_A_W4:    state_next = ST_IDLE;
            ST_F_RANGE: state_next = stat.range_bad ? ST_IDLE : ST_F_SIZE;
            ST_F_SIZE:  state_next = stat.size_bad ? ST_IDLE : ST_F_CHECK;
            ST_F_CHECK:
            begin
                if (!stat.walk_ok || stat.cur_ge_hdr)
                begin
                    state_next = ST_F_JUDGE;
                end
                else
                begin
                    state_next = ST_F_SZ;
                end
            end
            ST_F_SZ:    state_next = ST_F_NX;
            ST_F_NX:    state_next = stat.f_stop ? ST_F_JUDGE : ST_F_CHECK;
            ST_F_JUDGE:
            begin
                if (stat.overlap)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = stat.merge_next ? ST_F_MSZ : ST_F_W1;
                end
            end
            ST_F_MSZ:   state_next = ST_F_MLK;
            ST_F_MLK:   state_next = ST_F_W1;
            ST_F_W1:    state_next = ST_F_W2;
            ST_F_W2:
            begin
                if (!stat.merge_prev && stat.have_prev)
                begin
                    state_next = ST_F_W3;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_F_W3:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
        // a pool size write rebuilds the pool
        if (pool_wr)
        begin
            state_next = ST_CLEAR;
        end
    end

    // command outputs
    always_comb
    begin
        cmd             = '0;
        cmd.rd_sel      = RD_NONE;
        cmd.wr_sel      = WR_NONE;
        cmd.clear_start = pool_wr;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_A_CHECK:
            begin
                if (stat.walk_ok)
                begin
                    cmd.rd_sel = RD_CUR;
                    cmd.step   = 1'b1;
                end
            end
            ST_A_SZ:
            begin
                cmd.cap_sz = 1'b1;
                cmd.rd_sel = RD_CUR_LINK;
            end
            ST_A_NX:
            begin
                cmd.a_eval = 1'b1;
            end
            ST_A_DONE:
            begin
                if (!stat.have_t)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = STATUS_NOMEM;
                end
            end
            ST_A_W1:
            begin
                cmd.wr_sel = WR_SPLIT_SIZE;
            end
            ST_A_W2:
            begin
                cmd.wr_sel = WR_SPLIT_LINK;
            end
            ST_A_W3:
            begin
                if (stat.have_pt)
                begin
                    cmd.wr_sel = WR_PT_LINK;
                end
                else
                begin
                    cmd.head_alloc = 1'b1;
                end
            end
            ST_A_W4:
            begin
                cmd.wr_sel     = WR_T_SIZE;
                cmd.result     = 1'b1;
                cmd.res_status = STATUS_DONE;
                cmd.res_grant  = 1'b1;
            end
            ST_F_RANGE:
            begin
                if (stat.range_bad)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = STATUS_RANGE;
                end
                else
                begin
                    cmd.rd_sel = RD_HDR;
                end
            end
            ST_F_SIZE:
            begin
                cmd.cap_s = 1'b1;
                if (stat.size_bad)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = STATUS_RANGE;
                end
            end
            ST_F_CHECK:
            begin
                if (stat.walk_ok)
                begin
                    if (stat.cur_ge_hdr)
                    begin
                        cmd.f_nxt = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_CUR;
                        cmd.step   = 1'b1;
                    end
                end
            end
            ST_F_SZ:
            begin
                cmd.f_prev = 1'b1;
                cmd.rd_sel = RD_CUR_LINK;
            end
            ST_F_NX:
            begin
                cmd.f_adv = 1'b1;
            end
            ST_F_JUDGE:
            begin
                if (stat.overlap)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = STATUS_RANGE;
                end
                else
                begin
                    cmd.link_init = 1'b1;
                    if (stat.merge_next)
                    begin
                        cmd.rd_sel = RD_NXT;
                    end
                end
            end
            ST_F_MSZ:
            begin
                cmd.merge_sz = 1'b1;
                cmd.rd_sel   = RD_NXT_LINK;
            end
            ST_F_MLK:
            begin
                cmd.merge_lk = 1'b1;
            end
            ST_F_W1:
            begin
                cmd.wr_sel = stat.merge_prev ? WR_PREV_SIZE : WR_HDR_SIZE;
            end
            ST_F_W2:
            begin
                cmd.wr_sel = stat.merge_prev ? WR_PREV_LINK : WR_HDR_LINK;
                if (stat.merge_prev || !stat.have_prev)
                begin
                    cmd.head_free  = !stat.merge_prev;
                    cmd.result     = 1'b1;
                    cmd.res_status = STATUS_DONE;
                end
            end
            ST_F_W3:
            begin
                cmd.wr_sel     = WR_PREV_TO_HDR;
                cmd.result     = 1'b1;
                cmd.res_status = STATUS_DONE;
            end
            default:
            begin
                cmd.wr_sel = WR_NONE;
            end
        endcase
    end

    // an accepted transaction always leaves idle
    `SFLA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != ST_IDLE)
    // a result ends the transaction
    `SFLA_ASSERT_NEXT(a_result_idle, clk, rst_n, cmd.result && !pool_wr, state_reg == ST_IDLE)
    // no header write while idle
    `SFLA_ASSERT_IMPLY(a_idle_nowr, clk, rst_n, state_reg == ST_IDLE, cmd.wr_sel == WR_NONE)

endmodule

`default_nettype wire

// ----- src/sfla_dpath.sv -----
// ----------------------------------------------------------------------------
// sfla_dpath
// Datapath: walk registers, byte-banked pool memory, header arithmetic, result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_dpath
    import sfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire req_t              request,
    input  wire logic [FIT_W-1:0]  fit_mode,
    input  wire logic [ADDR_W-1:0] pool_bytes,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    output logic                   done,
    output res_t                   result
);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    // control registers
    logic                 head_valid_reg;
    logic                 head_big_reg;
    addr_t                head_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [STEP_W-1:0]    steps_reg;
    logic                 cur_fit_reg;
    logic                 have_prev_reg;
    logic                 have_t_reg;
    logic                 have_pt_reg;
    logic                 have_nxt_reg;
    logic                 done_reg;

    // payload registers
    req_t                 req_reg;
    logic [OFF_W-1:0]     need_reg;
    addr_t                cur_reg;
    addr_t                prev_reg;
    addr_t                t_reg;
    addr_t                pt_reg;
    addr_t                nxt_reg;
    word_t                sz_reg;
    word_t                prev_sz_reg;
    word_t                ts_reg;
    word_t                nt_reg;
    word_t                s_reg;
    word_t                link_reg;
    res_t                 result_reg;
    logic [LANE_W-1:0]    rd_lane_reg;
    logic [WORD_BYTES-1:0] rd_inr_reg;

    // memory side
    logic                 bank_we    [WORD_BYTES];
    logic [ROW_W-1:0]     bank_waddr [WORD_BYTES];
    logic [7:0]           bank_wdata [WORD_BYTES];
    logic [ROW_W-1:0]     bank_raddr [WORD_BYTES];
    logic [7:0]           bank_rdata [WORD_BYTES];
    logic [WORD_BYTES-1:0] rd_inr;
    addr_t                raddr;
    addr_t                waddr;
    word_t                wdata;
    logic                 wr_en;
    word_t                rdata;
    word_t                pool_word;

    // arithmetic
    logic [OFF_W-1:0]     need_in;
    logic                 head_fit;
    logic                 nx_fit;
    logic                 nx_stop;
    logic                 cand;
    logic                 take;
    logic                 take_first;
    word_t                need_ext;
    word_t                leftover;
    logic                 split;
    addr_t                split_addr;
    word_t                a_link;
    word_t                ts_m8;
    word_t                t_size;
    addr_t                hdr_a;
    addr_t                pool_less_hdr;
    logic                 range_bad;
    logic                 size_bad;
    logic [WORD_W:0]      prev_end;
    logic [WORD_W:0]      hdr_end;
    logic                 overlap;
    logic                 merge_next;
    logic                 merge_prev;

    // check that a link lands on a header that fits in the pool
    function automatic logic fits(input word_t v, input addr_t pool);
        logic [ADDR_W:0] fend;
        fend = {1'b0, v[ADDR_W-1:0]} + (ADDR_W+1)'(HDR_FREE);
        return (v[WORD_W-1:ADDR_W] == '0) && (fend <= {1'b0, pool});
    endfunction

    assign need_in  = (request.request_bytes < OFF_W'(WORD_BYTES)) ?
                      OFF_W'(WORD_BYTES) : request.request_bytes;
    assign head_fit = head_valid_reg && !head_big_reg &&
                      fits(WORD_W'(head_reg), pool_bytes);

    // walk decisions on the link word just read
    assign nx_fit     = fits(rdata, pool_bytes);
    assign nx_stop    = (rdata == '0) || (rdata <= WORD_W'(cur_reg));
    assign need_ext   = WORD_W'(need_reg);
    assign cand       = sz_reg >= (need_ext + WORD_W'(HDR_OCC));
    assign take_first = (fit_mode != FIT_BEST) && (fit_mode != FIT_WORST);
    always_comb
    begin
        case (fit_mode)
            FIT_BEST:  take = cand && (!have_t_reg || (sz_reg < ts_reg));
            FIT_WORST: take = cand && (!have_t_reg || (sz_reg > ts_reg));
            default:   take = cand;
        endcase
    end

    // split or absorb the chosen block
    assign leftover   = ts_reg - WORD_W'(HDR_OCC) - need_ext;
    assign split      = leftover >= WORD_W'(HDR_FREE);
    assign split_addr = t_reg + ADDR_W'(HDR_OCC) + ADDR_W'(need_reg);
    assign a_link     = split ? WORD_W'(split_addr) : nt_reg;
    assign ts_m8      = ts_reg - WORD_W'(HDR_OCC);
    assign t_size     = split ? (need_ext + WORD_W'(HDR_OCC)) : ts_reg;

    // free checks
    assign hdr_a         = ADDR_W'(req_reg.free_offset) - ADDR_W'(HDR_OCC);
    assign pool_less_hdr = pool_bytes - hdr_a;
    assign range_bad     = (req_reg.free_offset < OFF_W'(HDR_OCC)) ||
                           (ADDR_W'(req_reg.free_offset) >= pool_bytes);
    assign size_bad      = (rdata < WORD_W'(HDR_FREE)) || (rdata > WORD_W'(pool_less_hdr));
    assign prev_end      = {1'b0, prev_sz_reg} + (WORD_W+1)'(prev_reg);
    assign hdr_end       = {1'b0, s_reg} + (WORD_W+1)'(hdr_a);
    assign overlap       = (have_prev_reg && (prev_end > (WORD_W+1)'(hdr_a))) ||
                           (have_nxt_reg && (hdr_end > (WORD_W+1)'(nxt_reg)));
    assign merge_next    = have_nxt_reg && (hdr_end == (WORD_W+1)'(nxt_reg));
    assign merge_prev    = have_prev_reg && (prev_end == (WORD_W+1)'(hdr_a));

    // status to the controller
    always_comb
    begin
        stat            = '0;
        stat.walk_ok    = cur_fit_reg && (steps_reg < STEP_W'(MAX_WALK));
        stat.a_stop     = (cand && take_first) || nx_stop;
        stat.have_t     = have_t_reg;
        stat.split      = split;
        stat.have_pt    = have_pt_reg;
        stat.range_bad  = range_bad;
        stat.size_bad   = size_bad;
        stat.cur_ge_hdr = cur_reg >= hdr_a;
        stat.f_stop     = nx_stop;
        stat.overlap    = overlap;
        stat.merge_next = merge_next;
        stat.merge_prev = merge_prev;
        stat.have_prev  = have_prev_reg;
        stat.clear_last = (row_reg == ROW_W'(POOL_ROWS - 1));
    end

    // select read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:      raddr = cur_reg;
            RD_CUR_LINK: raddr = cur_reg + ADDR_W'(HDR_OCC);
            RD_HDR:      raddr = hdr_a;
            RD_NXT:      raddr = nxt_reg;
            RD_NXT_LINK: raddr = nxt_reg + ADDR_W'(HDR_OCC);
            default:     raddr = cur_reg;
        endcase
    end

    // select write address and data
    always_comb
    begin
        wr_en = 1'b1;
        waddr = hdr_a;
        wdata = s_reg;
        case (cmd.wr_sel)
            WR_SPLIT_SIZE:
            begin
                waddr = split_addr;
                wdata = leftover;
            end
            WR_SPLIT_LINK:
            begin
                waddr = split_addr + ADDR_W'(HDR_OCC);
                wdata = nt_reg;
            end
            WR_PT_LINK:
            begin
                waddr = pt_reg + ADDR_W'(HDR_OCC);
                wdata = a_link;
            end
            WR_T_SIZE:
            begin
                waddr = t_reg;
                wdata = t_size;
            end
            WR_PREV_SIZE:
            begin
                waddr = prev_reg;
                wdata = prev_sz_reg + s_reg;
            end
            WR_PREV_LINK:
            begin
                waddr = prev_reg + ADDR_W'(HDR_OCC);
                wdata = link_reg;
            end
            WR_HDR_SIZE:
            begin
                waddr = hdr_a;
                wdata = s_reg;
            end
            WR_HDR_LINK:
            begin
                waddr = hdr_a + ADDR_W'(HDR_OCC);
                wdata = link_reg;
            end
            WR_PREV_TO_HDR:
            begin
                waddr = prev_reg + ADDR_W'(HDR_OCC);
                wdata = WORD_W'(hdr_a);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign pool_word = WORD_W'(pool_bytes);

    // spread a word over the byte banks
    always_comb
    begin
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            logic [LANE_W-1:0] rj;
            logic [LANE_W-1:0] wj;
            logic [ADDR_W:0]   rba;
            logic [ADDR_W:0]   wba;
            rj  = LANE_W'(b) - raddr[LANE_W-1:0];
            wj  = LANE_W'(b) - waddr[LANE_W-1:0];
            rba = {1'b0, raddr} + (ADDR_W+1)'(rj);
            wba = {1'b0, waddr} + (ADDR_W+1)'(wj);
            rd_inr[b]     = rba < (ADDR_W+1)'(POOL_BYTES);
            bank_raddr[b] = rba[LANE_W +: ROW_W];
            if (cmd.clear_en)
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = row_reg;
                bank_wdata[b] = (row_reg == '0) ? pool_word[8*b +: 8] : 8'h00;
            end
            else
            begin
                bank_we[b]    = wr_en && (wba < (ADDR_W+1)'(POOL_BYTES));
                bank_waddr[b] = wba[LANE_W +: ROW_W];
                bank_wdata[b] = wdata[{wj, 3'b000} +: 8];
            end
        end
    end

    // gather the read word; bytes past the pool read as zero
    always_comb
    begin
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            logic [LANE_W-1:0] lane;
            lane = rd_lane_reg + LANE_W'(j);
            rdata[8*j +: 8] = rd_inr_reg[lane] ? bank_rdata[lane] : 8'h00;
        end
    end

    // byte banks
    for (genvar gb = 0; gb < WORD_BYTES; gb++)
    begin : g_bank
        sfla_ram #(
            .WIDTH (8),
            .DEPTH (POOL_ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[gb]),
            .waddr (bank_waddr[gb]),
            .wdata (bank_wdata[gb]),
            .raddr (bank_raddr[gb]),
            .rdata (bank_rdata[gb])
        );
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b1;
            head_big_reg   <= 1'b0;
            head_reg       <= '0;
            row_reg        <= '0;
            steps_reg      <= '0;
            cur_fit_reg    <= 1'b0;
            have_prev_reg  <= 1'b0;
            have_t_reg     <= 1'b0;
            have_pt_reg    <= 1'b0;
            have_nxt_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.result;
            // rebuild the pool as one free block
            if (cmd.clear_start)
            begin
                row_reg        <= '0;
                head_reg       <= '0;
                head_valid_reg <= 1'b1;
                head_big_reg   <= 1'b0;
            end
            else if (cmd.clear_en)
            begin
                row_reg <= row_reg + 1'b1;
            end
            if (cmd.head_alloc)
            begin
                head_reg       <= a_link[ADDR_W-1:0];
                head_big_reg   <= |a_link[31:ADDR_W];
                head_valid_reg <= (a_link != '0);
            end
            if (cmd.head_free)
            begin
                head_reg       <= hdr_a;
                head_big_reg   <= 1'b0;
                head_valid_reg <= 1'b1;
            end
            // start a walk
            if (cmd.load)
            begin
                steps_reg     <= '0;
                cur_fit_reg   <= head_fit;
                have_prev_reg <= 1'b0;
                have_t_reg    <= 1'b0;
                have_pt_reg   <= 1'b0;
                have_nxt_reg  <= 1'b0;
            end
            if (cmd.step)
            begin
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.a_eval)
            begin
                if (take)
                begin
                    have_t_reg  <= 1'b1;
                    have_pt_reg <= have_prev_reg;
                end
                if (!stat.a_stop)
                begin
                    have_prev_reg <= 1'b1;
                    cur_fit_reg   <= nx_fit;
                end
            end
            if (cmd.f_prev)
            begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.f_adv && !nx_stop)
            begin
                cur_fit_reg <= nx_fit;
            end
            if (cmd.f_nxt)
            begin
                have_nxt_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_lane_reg <= raddr[LANE_W-1:0];
        rd_inr_reg  <= rd_inr;
        if (cmd.load)
        begin
            req_reg  <= request;
            need_reg <= need_in;
            cur_reg  <= head_reg;
        end
        if (cmd.cap_sz)
        begin
            sz_reg <= rdata;
        end
        if (cmd.a_eval)
        begin
            if (take)
            begin
                t_reg  <= cur_reg;
                ts_reg <= sz_reg;
                nt_reg <= rdata;
                pt_reg <= prev_reg;
            end
            if (!stat.a_stop)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= rdata[ADDR_W-1:0];
            end
        end
        if (cmd.cap_s)
        begin
            s_reg <= rdata;
        end
        if (cmd.f_prev)
        begin
            prev_reg    <= cur_reg;
            prev_sz_reg <= rdata;
        end
        if (cmd.f_adv && !nx_stop)
        begin
            cur_reg <= rdata[ADDR_W-1:0];
        end
        if (cmd.f_nxt)
        begin
            nxt_reg <= cur_reg;
        end
        if (cmd.link_init)
        begin
            link_reg <= have_nxt_reg ? WORD_W'(nxt_reg) : '0;
        end
        if (cmd.merge_sz)
        begin
            s_reg <= s_reg + rdata;
        end
        if (cmd.merge_lk)
        begin
            link_reg <= rdata;
        end
        // form the result
        if (cmd.result)
        begin
            result_reg.status <= cmd.res_status;
            if (cmd.res_grant)
            begin
                result_reg.block_offset  <= OFF_W'(t_reg + ADDR_W'(HDR_OCC));
                result_reg.granted_bytes <= split ? need_reg : ts_m8[OFF_W-1:0];
            end
            else
            begin
                result_reg.block_offset  <= '0;
                result_reg.granted_bytes <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
